// ===== src/pnew_pkg.sv =====
// Shared types, constants and helpers for the pixel neighbour edge weight block.
`timescale 1ns / 1ps

package pnew_pkg;

    localparam int unsigned DEF_MAX_ROWS     = 256;
    localparam int unsigned DEF_MAX_COLS     = 256;
    localparam int unsigned DEF_MAX_OFFSETS  = 8;
    localparam int unsigned DEF_MAX_CHANNELS = 3;
    localparam int unsigned DEF_CHANNEL_BITS = 16;

    localparam int unsigned DIM_W      = 9;
    localparam int unsigned NOFS_W     = 4;
    localparam int unsigned NCH_W      = 2;
    localparam int unsigned OFS_W      = 8;
    localparam int unsigned PACK_W     = 64;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam int unsigned COORD_W   = 8;
    localparam int unsigned IN_CH_W   = 16;
    localparam int unsigned LIN_W     = 18;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned OFSNUM_W  = 3;
    localparam int unsigned COLOR_W   = 34;
    localparam int unsigned SPATIAL_W = 16;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_HEIGHT = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_NUM_OFFSETS  = 3'd2,
        REG_NUM_CHANNELS = 3'd3,
        REG_ROW_OFFSETS  = 3'd4,
        REG_COL_OFFSETS  = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    // Configuration as seen by the datapath, dimensions already capped
    typedef struct packed {
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  width;
        logic [NOFS_W-1:0] num_offsets;
        logic [NCH_W-1:0]  num_channels;
        logic [PACK_W-1:0] row_offsets;
        logic [PACK_W-1:0] col_offsets;
    } cfg_t;

    // Classified request travelling from front to back
    typedef struct packed {
        logic               is_query;
        logic               in_frame;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [LIN_W-1:0]   lidx;
    } req_t;

    function automatic logic [DIM_W-1:0] cap_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned top);
        if (32'(v) > top) begin
            return DIM_W'(top);
        end
        return v;
    endfunction

endpackage

// ===== src/pnew_front.sv =====
// Front end: takes input transfers, bounds-checks the pixel and forms its linear index.
`timescale 1ns / 1ps

module pnew_front #(
    parameter int unsigned MAX_CHANNELS = pnew_pkg::DEF_MAX_CHANNELS,
    parameter int unsigned CHANNEL_BITS = pnew_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pnew_pkg::cfg_t                       cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic [pnew_pkg::COORD_W-1:0]         s_pixel_row,
    input  logic [pnew_pkg::COORD_W-1:0]         s_pixel_col,
    input  logic [pnew_pkg::IN_CH_W-1:0]         s_channel_zero,
    input  logic [pnew_pkg::IN_CH_W-1:0]         s_channel_one,
    input  logic [pnew_pkg::IN_CH_W-1:0]         s_channel_two,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output pnew_pkg::req_t                       q_req,
    output logic [MAX_CHANNELS*CHANNEL_BITS-1:0] q_pix
);
    import pnew_pkg::*;

    localparam int unsigned PIX_W = MAX_CHANNELS * CHANNEL_BITS;

    logic             valid_reg;
    logic             valid_next;
    req_t             req_reg;
    req_t             req_next;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pix_next;
    logic [IN_CH_W-1:0] in_ch [3];
    logic             take;

    assign s_ready = !valid_reg || q_ready;
    assign take    = s_valid && s_ready;

    assign in_ch[0] = s_channel_zero;
    assign in_ch[1] = s_channel_one;
    assign in_ch[2] = s_channel_two;

    always_comb begin
        req_next.is_query = (s_req_type == REQ_QUERY);
        req_next.in_frame = ({1'b0, s_pixel_row} < cfg.height) &&
                            ({1'b0, s_pixel_col} < cfg.width);
        req_next.row      = s_pixel_row;
        req_next.col      = s_pixel_col;
        req_next.lidx     = LIN_W'(s_pixel_row) + LIN_W'(s_pixel_col) * LIN_W'(cfg.height);
        for (int d = 0; d < MAX_CHANNELS; d++) begin
            pix_next[d*CHANNEL_BITS +: CHANNEL_BITS] = in_ch[d][CHANNEL_BITS-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg <= req_next;
            pix_reg <= pix_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_req   = req_reg;
    assign q_pix   = pix_reg;

endmodule

// ===== src/pnew_queue.sv =====
// Short request queue between the front and back ends.
`timescale 1ns / 1ps

module pnew_queue #(
    parameter int unsigned WIDTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import pnew_pkg::*;

    localparam int unsigned DEPTH = QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== src/pnew_back.sv =====
// Back end: frame store, offset sequencer and edge weight pipeline.
`timescale 1ns / 1ps

module pnew_back #(
    parameter int unsigned MAX_ROWS     = pnew_pkg::DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS     = pnew_pkg::DEF_MAX_COLS,
    parameter int unsigned MAX_OFFSETS  = pnew_pkg::DEF_MAX_OFFSETS,
    parameter int unsigned MAX_CHANNELS = pnew_pkg::DEF_MAX_CHANNELS,
    parameter int unsigned CHANNEL_BITS = pnew_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pnew_pkg::cfg_t                       cfg,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  pnew_pkg::req_t                       q_req,
    input  logic [MAX_CHANNELS*CHANNEL_BITS-1:0] q_pix,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_edge_valid,
    output logic [pnew_pkg::INDEX_W-1:0]         m_left_index,
    output logic [pnew_pkg::INDEX_W-1:0]         m_right_index,
    output logic [pnew_pkg::OFSNUM_W-1:0]        m_offset_number,
    output logic [pnew_pkg::COLOR_W-1:0]         m_color_weight,
    output logic [pnew_pkg::SPATIAL_W-1:0]       m_spatial_weight,
    output logic                                 m_last_edge
);
    import pnew_pkg::*;

    localparam int unsigned PIX_W      = MAX_CHANNELS * CHANNEL_BITS;
    localparam int unsigned PROD_W     = 2 * CHANNEL_BITS;
    localparam int unsigned STORE_ROWS = (MAX_ROWS < 511) ? MAX_ROWS : 511;
    localparam int unsigned STORE_COLS = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int unsigned DEPTH      = STORE_ROWS * STORE_COLS;
    localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SEL_W      = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
    localparam int unsigned RC_W       = COORD_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEFT = 4'b0010,
        ST_MASK = 4'b0100,
        ST_RUN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [COORD_W-1:0]     row_reg;
    logic [COORD_W-1:0]     col_reg;
    logic [LIN_W-1:0]       lidx_reg;
    logic                   inside_reg;
    logic [PIX_W-1:0]       left_pix_reg;
    logic [MAX_OFFSETS-1:0] pend_reg;
    logic [MAX_OFFSETS-1:0] pend_next;
    logic                   none_reg;
    logic                   none_next;

    logic [PIX_W-1:0]  store_mem [DEPTH];
    logic [PIX_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    logic pop;
    logic adv;
    logic pipe_empty;

    // offset mask
    logic signed [RC_W-1:0] mk_r [MAX_OFFSETS];
    logic signed [RC_W-1:0] mk_c [MAX_OFFSETS];
    logic [MAX_OFFSETS-1:0] mask;

    // issue
    logic [SEL_W-1:0]       sel;
    logic [MAX_OFFSETS-1:0] pick;
    logic [MAX_OFFSETS-1:0] pend_left;
    logic signed [OFS_W-1:0] iss_ro;
    logic signed [OFS_W-1:0] iss_co;
    logic signed [RC_W-1:0]  iss_r;
    logic signed [RC_W-1:0]  iss_c;
    logic [LIN_W-1:0]        iss_ridx;
    logic                    issue;
    logic                    issue_ev;
    logic                    issue_last;

    // stage 1
    logic                    s1_valid_reg;
    logic                    s1_ev_reg;
    logic                    s1_last_reg;
    logic [OFSNUM_W-1:0]     s1_sel_reg;
    logic [LIN_W-1:0]        s1_ridx_reg;
    logic signed [OFS_W-1:0] s1_ro_reg;
    logic signed [OFS_W-1:0] s1_co_reg;

    // stage 2
    logic                    s2_valid_reg;
    logic                    s2_ev_reg;
    logic                    s2_last_reg;
    logic [OFSNUM_W-1:0]     s2_sel_reg;
    logic [LIN_W-1:0]        s2_ridx_reg;
    logic [SPATIAL_W-1:0]    s2_sq_reg;
    logic signed [SPATIAL_W-1:0] ro_x;
    logic signed [SPATIAL_W-1:0] co_x;
    logic [SPATIAL_W-1:0]    sq_next;

    // stage 3
    logic                    s3_valid_reg;
    logic                    s3_ev_reg;
    logic                    s3_last_reg;
    logic [OFSNUM_W-1:0]     s3_sel_reg;
    logic [LIN_W-1:0]        s3_ridx_reg;
    logic [SPATIAL_W-1:0]    s3_sq_reg;
    logic [PROD_W-1:0]       s3_prod_reg [MAX_CHANNELS];
    logic [CHANNEL_BITS-1:0] pa [MAX_CHANNELS];
    logic [CHANNEL_BITS-1:0] pb [MAX_CHANNELS];
    logic [CHANNEL_BITS-1:0] diff [MAX_CHANNELS];
    logic [PROD_W-1:0]       prod_next [MAX_CHANNELS];
    logic [COLOR_W-1:0]      color_sum;

    // result register
    logic                  m_valid_reg;
    logic                  m_edge_valid_reg;
    logic [INDEX_W-1:0]    m_left_index_reg;
    logic [INDEX_W-1:0]    m_right_index_reg;
    logic [OFSNUM_W-1:0]   m_offset_number_reg;
    logic [COLOR_W-1:0]    m_color_weight_reg;
    logic [SPATIAL_W-1:0]  m_spatial_weight_reg;
    logic                  m_last_edge_reg;

    assign pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign adv        = !m_valid_reg || m_ready;
    assign q_ready    = (state_reg == ST_IDLE) && pipe_empty;
    assign pop        = q_valid && q_ready;
    assign wr_en      = pop && !q_req.is_query && q_req.in_frame;
    assign rd_en      = (state_reg == ST_LEFT) || (adv && s1_valid_reg);
    assign rd_addr    = (state_reg == ST_LEFT) ? lidx_reg[ADDR_W-1:0]
                                               : s1_ridx_reg[ADDR_W-1:0];

    // frame store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[q_req.lidx[ADDR_W-1:0]] <= q_pix;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb begin
        mask = '0;
        for (int i = 0; i < MAX_OFFSETS; i++) begin
            mk_r[i] = signed'({2'b00, row_reg}) +
                      RC_W'(signed'(cfg.row_offsets[i*OFS_W +: OFS_W]));
            mk_c[i] = signed'({2'b00, col_reg}) +
                      RC_W'(signed'(cfg.col_offsets[i*OFS_W +: OFS_W]));
            mask[i] = inside_reg && (NOFS_W'(i) < cfg.num_offsets) &&
                      !mk_r[i][RC_W-1] && (mk_r[i][DIM_W-1:0] < cfg.height) &&
                      !mk_c[i][RC_W-1] && (mk_c[i][DIM_W-1:0] < cfg.width);
        end
    end

    always_comb begin
        sel = '0;
        for (int i = MAX_OFFSETS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = SEL_W'(i);
            end
        end
        pick      = '0;
        pick[sel] = 1'b1;
        pend_left = pend_reg & ~pick;
        iss_ro    = signed'(cfg.row_offsets[{sel, 3'b000} +: OFS_W]);
        iss_co    = signed'(cfg.col_offsets[{sel, 3'b000} +: OFS_W]);
        iss_r     = signed'({2'b00, row_reg}) + RC_W'(iss_ro);
        iss_c     = signed'({2'b00, col_reg}) + RC_W'(iss_co);
        iss_ridx  = LIN_W'(iss_r[DIM_W-1:0]) +
                    LIN_W'(iss_c[DIM_W-1:0]) * LIN_W'(cfg.height);
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        none_next  = none_reg;
        issue      = 1'b0;
        issue_ev   = 1'b0;
        issue_last = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (pop && q_req.is_query) begin
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT: begin
                state_next = ST_MASK;
            end
            ST_MASK: begin
                pend_next  = mask;
                none_next  = (mask == '0);
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (adv) begin
                    issue = 1'b1;
                    if (none_reg) begin
                        issue_last = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        issue_ev   = 1'b1;
                        issue_last = (pend_left == '0);
                        pend_next  = pend_left;
                        if (pend_left == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ro_x    = SPATIAL_W'(s1_ro_reg);
        co_x    = SPATIAL_W'(s1_co_reg);
        sq_next = unsigned'(SPATIAL_W'(ro_x * ro_x)) + unsigned'(SPATIAL_W'(co_x * co_x));
    end

    always_comb begin
        for (int d = 0; d < MAX_CHANNELS; d++) begin
            pa[d]        = left_pix_reg[d*CHANNEL_BITS +: CHANNEL_BITS];
            pb[d]        = rd_data_reg[d*CHANNEL_BITS +: CHANNEL_BITS];
            diff[d]      = (pa[d] >= pb[d]) ? (pa[d] - pb[d]) : (pb[d] - pa[d]);
            prod_next[d] = PROD_W'(diff[d]) * PROD_W'(diff[d]);
        end
    end

    always_comb begin
        color_sum = '0;
        for (int d = 0; d < MAX_CHANNELS; d++) begin
            if (NCH_W'(d) < cfg.num_channels) begin
                color_sum = color_sum + COLOR_W'(s3_prod_reg[d]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            none_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            none_reg  <= none_next;
            if (adv) begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                m_valid_reg  <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_req.is_query) begin
            row_reg    <= q_req.row;
            col_reg    <= q_req.col;
            lidx_reg   <= q_req.lidx;
            inside_reg <= q_req.in_frame;
        end
        if (state_reg == ST_MASK) begin
            left_pix_reg <= rd_data_reg;
        end
        if (adv) begin
            if (issue) begin
                s1_ev_reg   <= issue_ev;
                s1_last_reg <= issue_last;
                s1_sel_reg  <= OFSNUM_W'(sel);
                s1_ridx_reg <= iss_ridx;
                s1_ro_reg   <= iss_ro;
                s1_co_reg   <= iss_co;
            end
            s2_ev_reg   <= s1_ev_reg;
            s2_last_reg <= s1_last_reg;
            s2_sel_reg  <= s1_sel_reg;
            s2_ridx_reg <= s1_ridx_reg;
            s2_sq_reg   <= sq_next;
            s3_ev_reg   <= s2_ev_reg;
            s3_last_reg <= s2_last_reg;
            s3_sel_reg  <= s2_sel_reg;
            s3_ridx_reg <= s2_ridx_reg;
            s3_sq_reg   <= s2_sq_reg;
            for (int d = 0; d < MAX_CHANNELS; d++) begin
                s3_prod_reg[d] <= prod_next[d];
            end
            if (s3_valid_reg) begin
                m_edge_valid_reg     <= s3_ev_reg;
                m_left_index_reg     <= lidx_reg[INDEX_W-1:0];
                m_right_index_reg    <= s3_ev_reg ? s3_ridx_reg[INDEX_W-1:0] : '0;
                m_offset_number_reg  <= s3_ev_reg ? s3_sel_reg : '0;
                m_color_weight_reg   <= s3_ev_reg ? color_sum : '0;
                m_spatial_weight_reg <= s3_ev_reg ? s3_sq_reg : '0;
                m_last_edge_reg      <= s3_last_reg;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_edge_valid     = m_edge_valid_reg;
    assign m_left_index     = m_left_index_reg;
    assign m_right_index    = m_right_index_reg;
    assign m_offset_number  = m_offset_number_reg;
    assign m_color_weight   = m_color_weight_reg;
    assign m_spatial_weight = m_spatial_weight_reg;
    assign m_last_edge      = m_last_edge_reg;

endmodule

// ===== src/pixel_neighbour_edge_weights.sv =====
// Pixel neighbour edge weights: config registers, front end, request queue and back end.
// Front end registers each transfer into the queue; the back end stores a load on taking it.
// The back end takes a request only when idle and its pipeline is empty; a query steps through
// ST_LEFT, ST_MASK and ST_RUN, issuing an edge per in-range offset into the 3-stage pipeline.
// Reset clears control state and config (height, width, offsets, channels 1; offset tables 0);
// the frame store is not cleared and holds undefined data until loaded.
`timescale 1ns / 1ps

module pixel_neighbour_edge_weights #(
    parameter int unsigned MAX_ROWS     = pnew_pkg::DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS     = pnew_pkg::DEF_MAX_COLS,
    parameter int unsigned MAX_OFFSETS  = pnew_pkg::DEF_MAX_OFFSETS,
    parameter int unsigned MAX_CHANNELS = pnew_pkg::DEF_MAX_CHANNELS,
    parameter int unsigned CHANNEL_BITS = pnew_pkg::DEF_CHANNEL_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pnew_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pnew_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [pnew_pkg::COORD_W-1:0]      s_pixel_row,
    input  logic [pnew_pkg::COORD_W-1:0]      s_pixel_col,
    input  logic [pnew_pkg::IN_CH_W-1:0]      s_channel_zero,
    input  logic [pnew_pkg::IN_CH_W-1:0]      s_channel_one,
    input  logic [pnew_pkg::IN_CH_W-1:0]      s_channel_two,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_edge_valid,
    output logic [pnew_pkg::INDEX_W-1:0]      m_left_index,
    output logic [pnew_pkg::INDEX_W-1:0]      m_right_index,
    output logic [pnew_pkg::OFSNUM_W-1:0]     m_offset_number,
    output logic [pnew_pkg::COLOR_W-1:0]      m_color_weight,
    output logic [pnew_pkg::SPATIAL_W-1:0]    m_spatial_weight,
    output logic                              m_last_edge
);
    import pnew_pkg::*;

    localparam int unsigned PIX_W = MAX_CHANNELS * CHANNEL_BITS;
    localparam int unsigned Q_W   = $bits(req_t) + PIX_W;

    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  height_next;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  width_next;
    logic [NOFS_W-1:0] nofs_reg;
    logic [NOFS_W-1:0] nofs_next;
    logic [NCH_W-1:0]  nch_reg;
    logic [NCH_W-1:0]  nch_next;
    logic [PACK_W-1:0] row_ofs_reg;
    logic [PACK_W-1:0] row_ofs_next;
    logic [PACK_W-1:0] col_ofs_reg;
    logic [PACK_W-1:0] col_ofs_next;

    cfg_t             cfg;
    logic             fq_valid;
    logic             fq_ready;
    req_t             fq_req;
    logic [PIX_W-1:0] fq_pix;
    logic             bq_valid;
    logic             bq_ready;
    req_t             bq_req;
    logic [PIX_W-1:0] bq_pix;
    logic [Q_W-1:0]   bq_data;

    always_comb begin
        height_next  = height_reg;
        width_next   = width_reg;
        nofs_next    = nofs_reg;
        nch_next     = nch_reg;
        row_ofs_next = row_ofs_reg;
        col_ofs_next = col_ofs_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_HEIGHT: height_next  = cfg_wdata[DIM_W-1:0];
                REG_IMAGE_WIDTH:  width_next   = cfg_wdata[DIM_W-1:0];
                REG_NUM_OFFSETS:  nofs_next    = cfg_wdata[NOFS_W-1:0];
                REG_NUM_CHANNELS: nch_next     = cfg_wdata[NCH_W-1:0];
                REG_ROW_OFFSETS:  row_ofs_next = cfg_wdata[PACK_W-1:0];
                REG_COL_OFFSETS:  col_ofs_next = cfg_wdata[PACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg  <= DIM_W'(1);
            width_reg   <= DIM_W'(1);
            nofs_reg    <= NOFS_W'(1);
            nch_reg     <= NCH_W'(1);
            row_ofs_reg <= '0;
            col_ofs_reg <= '0;
        end else begin
            height_reg  <= height_next;
            width_reg   <= width_next;
            nofs_reg    <= nofs_next;
            nch_reg     <= nch_next;
            row_ofs_reg <= row_ofs_next;
            col_ofs_reg <= col_ofs_next;
        end
    end

    assign cfg.height       = cap_dim(height_reg, MAX_ROWS);
    assign cfg.width        = cap_dim(width_reg, MAX_COLS);
    assign cfg.num_offsets  = nofs_reg;
    assign cfg.num_channels = nch_reg;
    assign cfg.row_offsets  = row_ofs_reg;
    assign cfg.col_offsets  = col_ofs_reg;

    pnew_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_pixel_row    (s_pixel_row),
        .s_pixel_col    (s_pixel_col),
        .s_channel_zero (s_channel_zero),
        .s_channel_one  (s_channel_one),
        .s_channel_two  (s_channel_two),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_req          (fq_req),
        .q_pix          (fq_pix)
    );

    pnew_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_req, fq_pix}),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    assign {bq_req, bq_pix} = bq_data;

    pnew_back #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_OFFSETS  (MAX_OFFSETS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .q_valid          (bq_valid),
        .q_ready          (bq_ready),
        .q_req            (bq_req),
        .q_pix            (bq_pix),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_valid     (m_edge_valid),
        .m_left_index     (m_left_index),
        .m_right_index    (m_right_index),
        .m_offset_number  (m_offset_number),
        .m_color_weight   (m_color_weight),
        .m_spatial_weight (m_spatial_weight),
        .m_last_edge      (m_last_edge)
    );

endmodule

// ===== tb/pixel_neighbour_edge_weights_tb.sv =====
// Self-checking testbench for the pixel neighbour edge weight block: predicted edge stream.
`timescale 1ns / 1ps

module pixel_neighbour_edge_weights_tb;
    import pnew_pkg::*;

    localparam int unsigned STORE_DEPTH   = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int unsigned COORD_MAX     = (1 << COORD_W) - 1;
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS  = 360;
    localparam int unsigned PHASE_ITEMS   = 30;
    localparam int unsigned PIXEL_W       = DEF_MAX_CHANNELS * IN_CH_W;

    typedef struct packed {
        req_type_t          kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [IN_CH_W-1:0] ch0;
        logic [IN_CH_W-1:0] ch1;
        logic [IN_CH_W-1:0] ch2;
    } pixel_req_t;

    typedef struct packed {
        logic                 edge_valid;
        logic [INDEX_W-1:0]   left_index;
        logic [INDEX_W-1:0]   right_index;
        logic [OFSNUM_W-1:0]  offset_number;
        logic [COLOR_W-1:0]   color_weight;
        logic [SPATIAL_W-1:0] spatial_weight;
        logic                 last_edge;
    } edge_result_t;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_req_type     = 1'b0;
    logic [COORD_W-1:0]    s_pixel_row    = '0;
    logic [COORD_W-1:0]    s_pixel_col    = '0;
    logic [IN_CH_W-1:0]    s_channel_zero = '0;
    logic [IN_CH_W-1:0]    s_channel_one  = '0;
    logic [IN_CH_W-1:0]    s_channel_two  = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_edge_valid;
    logic [INDEX_W-1:0]    m_left_index;
    logic [INDEX_W-1:0]    m_right_index;
    logic [OFSNUM_W-1:0]   m_offset_number;
    logic [COLOR_W-1:0]    m_color_weight;
    logic [SPATIAL_W-1:0]  m_spatial_weight;
    logic                  m_last_edge;

    pixel_neighbour_edge_weights dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_pixel_row      (s_pixel_row),
        .s_pixel_col      (s_pixel_col),
        .s_channel_zero   (s_channel_zero),
        .s_channel_one    (s_channel_one),
        .s_channel_two    (s_channel_two),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_valid     (m_edge_valid),
        .m_left_index     (m_left_index),
        .m_right_index    (m_right_index),
        .m_offset_number  (m_offset_number),
        .m_color_weight   (m_color_weight),
        .m_spatial_weight (m_spatial_weight),
        .m_last_edge      (m_last_edge)
    );

    // Predictor state: shadow registers and frame copy
    logic [DIM_W-1:0]  height_cfg   = DIM_W'(1);
    logic [DIM_W-1:0]  width_cfg    = DIM_W'(1);
    logic [NOFS_W-1:0] offsets_cfg  = NOFS_W'(1);
    logic [NCH_W-1:0]  channels_cfg = NCH_W'(1);
    logic [PACK_W-1:0] row_ofs_cfg  = '0;
    logic [PACK_W-1:0] col_ofs_cfg  = '0;
    logic [DEF_MAX_CHANNELS-1:0][IN_CH_W-1:0] frame_copy [STORE_DEPTH];

    // Pixels that will have been loaded once the queued transfers are through
    bit staged [STORE_DEPTH];

    pixel_req_t   pending_reqs[$];
    pixel_req_t   offered_req;
    edge_result_t expected_edges[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned loads_done     = 0;
    int unsigned queries_done   = 0;
    int unsigned edges_seen     = 0;
    int unsigned items_queued   = 0;
    int unsigned settings_used  = 0;
    int unsigned quiet_cycles   = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned rows_in_use();
        return (height_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(height_cfg);
    endfunction

    function automatic int unsigned cols_in_use();
        return (width_cfg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(width_cfg);
    endfunction

    function automatic int unsigned offsets_in_use();
        return (offsets_cfg > DEF_MAX_OFFSETS) ? DEF_MAX_OFFSETS : int'(offsets_cfg);
    endfunction

    function automatic bit in_image(input int r, input int c);
        return r >= 0 && c >= 0 && r < int'(rows_in_use()) && c < int'(cols_in_use());
    endfunction

    function automatic int unsigned linear_index(input int r, input int c);
        return int'(r) + int'(c) * int'(rows_in_use());
    endfunction

    function automatic int offset_of(input logic [PACK_W-1:0] ofs_word, input int unsigned i);
        logic signed [OFS_W-1:0] b;
        b = ofs_word[OFS_W*i +: OFS_W];
        return int'(b);
    endfunction

    task automatic apply_request(input pixel_req_t rq);
        int unsigned  lidx;
        int unsigned  ridx;
        int unsigned  nch;
        int           r;
        int           c;
        int           ro;
        int           co;
        longint unsigned a;
        longint unsigned b;
        longint unsigned cw;
        edge_result_t e;
        edge_result_t found[$];
        lidx = linear_index(rq.row, rq.col);
        if (rq.kind == REQ_LOAD) begin
            loads_done++;
            if (in_image(rq.row, rq.col)) begin
                frame_copy[lidx] = {rq.ch2, rq.ch1, rq.ch0};
            end
            return;
        end
        queries_done++;
        nch = (channels_cfg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : int'(channels_cfg);
        if (in_image(rq.row, rq.col)) begin
            for (int i = 0; i < int'(offsets_in_use()); i++) begin
                ro = offset_of(row_ofs_cfg, i);
                co = offset_of(col_ofs_cfg, i);
                r = int'(rq.row) + ro;
                c = int'(rq.col) + co;
                if (in_image(r, c)) begin
                    ridx = linear_index(r, c);
                    cw = 0;
                    for (int d = 0; d < int'(nch); d++) begin
                        a = frame_copy[lidx][d];
                        b = frame_copy[ridx][d];
                        cw += (a >= b) ? (a - b) * (a - b) : (b - a) * (b - a);
                    end
                    e.edge_valid     = 1'b1;
                    e.left_index     = INDEX_W'(lidx);
                    e.right_index    = INDEX_W'(ridx);
                    e.offset_number  = OFSNUM_W'(i);
                    e.color_weight   = COLOR_W'(cw);
                    e.spatial_weight = SPATIAL_W'(ro * ro + co * co);
                    e.last_edge      = 1'b0;
                    found = {found, e};
                end
            end
        end
        if (found.size() == 0) begin
            e = '0;
            e.left_index = INDEX_W'(lidx);
            found = {found, e};
        end
        foreach (found[j]) begin
            e = found[j];
            e.last_edge = (j == found.size() - 1);
            expected_edges = {expected_edges, e};
        end
    endtask

    function automatic logic [IN_CH_W-1:0] pick_channel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        return IN_CH_W'($urandom);
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        return {pick_channel(), pick_channel(), pick_channel()};
    endfunction

    task automatic queue_load(input int r, input int c, input logic [PIXEL_W-1:0] px);
        pixel_req_t rq;
        rq.kind = REQ_LOAD;
        rq.row  = COORD_W'(r);
        rq.col  = COORD_W'(c);
        rq.ch0  = px[0 +: IN_CH_W];
        rq.ch1  = px[IN_CH_W +: IN_CH_W];
        rq.ch2  = px[2*IN_CH_W +: IN_CH_W];
        pending_reqs = {pending_reqs, rq};
        items_queued++;
        if (in_image(r, c)) begin
            staged[linear_index(r, c)] = 1'b1;
        end
    endtask

    task automatic queue_query(input int r, input int c);
        pixel_req_t rq;
        rq.kind = REQ_QUERY;
        rq.row  = COORD_W'(r);
        rq.col  = COORD_W'(c);
        rq.ch0  = IN_CH_W'($urandom);
        rq.ch1  = IN_CH_W'($urandom);
        rq.ch2  = IN_CH_W'($urandom);
        pending_reqs = {pending_reqs, rq};
        items_queued++;
    endtask

    // Loads the pixel and any in-range neighbour not yet held, then queries it
    task automatic queue_covered_query(input int r, input int c);
        int nr;
        int nc;
        if (in_image(r, c)) begin
            if (!staged[linear_index(r, c)]) queue_load(r, c, random_pixel());
            for (int i = 0; i < int'(offsets_in_use()); i++) begin
                nr = r + offset_of(row_ofs_cfg, i);
                nc = c + offset_of(col_ofs_cfg, i);
                if (in_image(nr, nc) && !staged[linear_index(nr, nc)]) begin
                    queue_load(nr, nc, random_pixel());
                end
            end
        end
        queue_query(r, c);
    endtask

    task automatic queue_random_item();
        int unsigned roll;
        int          r;
        int          c;
        bit          full;
        bit          empty;
        roll  = $urandom_range(99);
        full  = rows_in_use() > COORD_MAX && cols_in_use() > COORD_MAX;
        empty = rows_in_use() == 0 || cols_in_use() == 0;
        if (empty) begin
            r = $urandom_range(COORD_MAX);
            c = $urandom_range(COORD_MAX);
            if (roll < 60) queue_query(r, c);
            else queue_load(r, c, random_pixel());
        end else if (!full && roll >= 75) begin
            if (rows_in_use() <= COORD_MAX) begin
                r = $urandom_range(COORD_MAX, rows_in_use());
                c = $urandom_range(COORD_MAX);
            end else begin
                r = $urandom_range(COORD_MAX);
                c = $urandom_range(COORD_MAX, cols_in_use());
            end
            if (roll < 85) queue_query(r, c);
            else queue_load(r, c, random_pixel());
        end else begin
            r = $urandom_range(rows_in_use() - 1);
            c = $urandom_range(cols_in_use() - 1);
            if (roll >= 60 && roll < 75) queue_load(r, c, random_pixel());
            else queue_covered_query(r, c);
        end
    endtask

    function automatic logic [PACK_W-1:0] random_offsets(input bit wide);
        logic [PACK_W-1:0] v;
        for (int i = 0; i < DEF_MAX_OFFSETS; i++) begin
            v[OFS_W*i +: OFS_W] = wide ? OFS_W'($urandom) : OFS_W'($urandom_range(6) - 3);
        end
        return v;
    endfunction

    function automatic int unsigned random_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return $urandom_range(511, 257);
        if (roll < 20) return 256;
        if (roll < 25) return 1;
        return $urandom_range(16, 1);
    endfunction

    // Wait for the sender queue and the expected edges to empty, then for the given extra settling time
    task automatic settle(input int unsigned extra);
        while (pending_reqs.size() != 0 || s_valid || expected_edges.size() != 0) begin
            @(negedge aclk);
        end
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_IMAGE_HEIGHT: height_cfg   = DIM_W'(v);
            REG_IMAGE_WIDTH:  width_cfg    = DIM_W'(v);
            REG_NUM_OFFSETS:  offsets_cfg  = NOFS_W'(v);
            REG_NUM_CHANNELS: channels_cfg = NCH_W'(v);
            REG_ROW_OFFSETS:  row_ofs_cfg  = v;
            REG_COL_OFFSETS:  col_ofs_cfg  = v;
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned h, input int unsigned w,
                             input int unsigned k, input int unsigned ch,
                             input logic [PACK_W-1:0] ro, input logic [PACK_W-1:0] co);
        settle(SETTLE_CYCLES);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_NUM_OFFSETS, CFG_DATA_W'(k));
        write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(ch));
        write_reg(REG_ROW_OFFSETS, ro);
        write_reg(REG_COL_OFFSETS, co);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_request(offered_req);
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered_req = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_req_type     <= offered_req.kind;
                    s_pixel_row    <= offered_req.row;
                    s_pixel_col    <= offered_req.col;
                    s_channel_zero <= offered_req.ch0;
                    s_channel_one  <= offered_req.ch1;
                    s_channel_two  <= offered_req.ch2;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Result monitor
    always @(posedge aclk) begin
        edge_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_valid && m_ready) begin
                edges_seen++;
                if (expected_edges.size() == 0) begin
                    $error("result transfer with no edge expected");
                    fail_count++;
                end else begin
                    want = expected_edges.pop_front();
                    check_field("edge_valid", want.edge_valid, m_edge_valid);
                    check_field("left_index", want.left_index, m_left_index);
                    check_field("right_index", want.right_index, m_right_index);
                    check_field("offset_number", want.offset_number, m_offset_number);
                    check_field("color_weight", want.color_weight, m_color_weight);
                    check_field("spatial_weight", want.spatial_weight, m_spatial_weight);
                    check_field("last_edge", want.last_edge, m_last_edge);
                end
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("pixel_neighbour_edge_weights_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        int unsigned goal;
        int unsigned half;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: one pixel image, zero offset points at itself
        queue_load(0, 0, random_pixel());
        queue_query(0, 0);
        queue_query(5, 5);
        queue_load(3, 0, random_pixel());

        // Full frame, offsets at both ends of the signed byte range
        configure(256, 256, 8, 3, 64'h80010001_00FF7F80, 64'h80010100_FF00807F);
        queue_load(255, 255, '1);
        queue_load(254, 255, '0);
        queue_covered_query(255, 255);
        queue_covered_query(0, 0);
        queue_covered_query(128, 128);

        goal  = items_queued + RANDOM_ITEMS;
        phase = 0;
        while (items_queued < goal) begin
            case (phase)
                0: configure(0, 12, 3, 2, random_offsets(1'b0), random_offsets(1'b0));
                1: configure(9, 0, 8, 3, random_offsets(1'b0), random_offsets(1'b0));
                2: configure(511, 511, 15, 3, random_offsets(1'b1), random_offsets(1'b0));
                3: configure(6, 5, 0, 3, random_offsets(1'b0), random_offsets(1'b0));
                4: configure(4, 7, 8, 0, random_offsets(1'b0), random_offsets(1'b0));
                default: configure(random_dim(), random_dim(), $urandom_range(15, 1),
                                   $urandom_range(3), random_offsets($urandom_range(3) == 0),
                                   random_offsets($urandom_range(3) == 0));
            endcase
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            // odd phases hold the sender back until the block has drained
            repeat (2) begin
                half = items_queued + PHASE_ITEMS / 2;
                while (items_queued < half) queue_random_item();
                if (phase % 2 == 1) settle(0);
            end
            phase++;
        end

        settle(SETTLE_CYCLES);
        $display("Covered %0d loads and %0d queries over %0d register settings,",
                 loads_done, queries_done, settings_used);
        $display("with %0d edge results checked in order against the predicted stream.",
                 edges_seen);
        if (fail_count == 0 && expected_edges.size() == 0) begin
            $display("pixel_neighbour_edge_weights_tb: PASS");
        end else begin
            $display("pixel_neighbour_edge_weights_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pnew_pkg.sv
src/pnew_front.sv
src/pnew_queue.sv
src/pnew_back.sv
src/pixel_neighbour_edge_weights.sv
tb/pixel_neighbour_edge_weights_tb.sv
